/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files that check their own logic; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never comes true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_RST(lbl, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/mhpt_pkg.sv */
// Package with types, codes and helpers for the header parameter tokenizer.
package mhpt_pkg;

  // Results that one input byte can cause at most
  localparam int MaxRes  = 4;
  localparam int ResIdxW = $clog2(MaxRes);
  localparam int ResCntW = $clog2(MaxRes + 1);

  // Entries of the queue between front and back
  localparam int QDepth = 2;

  // Characters of interest
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] CaseOfs  = 8'h20;

  typedef enum logic [3:0] {
    PhMainSkip   = 4'd0,
    PhMainBare   = 4'd1,
    PhMainQuoted = 4'd2,
    PhKeySep     = 4'd3,
    PhKey        = 4'd4,
    PhKeyBlank   = 4'd5,
    PhValSkip    = 4'd6,
    PhValBare    = 4'd7,
    PhValQuoted  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KMain    = 3'd0,
    KKey     = 3'd1,
    KVal     = 3'd2,
    KMainEnd = 3'd3,
    KPairEnd = 3'd4,
    KLineEnd = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // One tagged byte without its position flag
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

  // All results of one input byte
  typedef struct packed {
    logic [ResCntW-1:0]      cnt;
    res_t [MaxRes-1:0]       res;
  } rec_t;

  // Write side of the queue
  typedef struct packed {
    logic valid;
    rec_t rec;
  } q_wr_t;

  // Append one result to a record
  function automatic rec_t rec_add(rec_t r, kind_e k, logic [7:0] b);
    rec_t o;
    o = r;
    if (r.cnt < ResCntW'(MaxRes)) begin
      o.res[r.cnt[ResIdxW-1:0]].kind = k;
      o.res[r.cnt[ResIdxW-1:0]].data = b;
      o.cnt = r.cnt + ResCntW'(1);
    end
    return o;
  endfunction

endpackage

/* hw/rtl/mime_header_param_tokenizer.sv */
// Top level of the header parameter tokenizer: front end, queue and back end.
//
// Input channel (in_valid_i, in_stall_o, in_data_i) carries one header byte per
// transaction with a flag on the final byte of the line. Output channel
// (out_valid_o, out_stall_i, out_data_o) carries one tagged byte or end marker
// per transaction, with run_last set on the final result of each input byte.
// The front end classifies a byte in the cycle it is accepted and writes all of
// its results (zero to four) as one record into a two-entry queue; bytes that
// cause no result use no queue space. The back end sends the head record one
// result per cycle unless the receiver stalls. Throughput is one input byte per
// cycle while each byte causes at most one result and the receiver does not
// stall; a byte with more results holds the output until the single result
// port of the back end has sent them all. When the receiver stalls, the queue
// fills and in_stall_o rises once both entries are occupied. Reset empties the
// queue and returns the parse phase to skipping blanks before the main value.
`include "assert_macros.svh"

module mime_header_param_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mhpt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhpt_pkg::out_item_t out_data_o
);

  mhpt_pkg::q_wr_t q_wr;
  mhpt_pkg::rec_t  head;
  logic            full, empty, pop, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mhpt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .accept_i  (accept),
    .q_wr_o    (q_wr)
  );

  mhpt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  mhpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Records are never written into a full queue
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, q_wr.valid && full, "push into full queue")
  // A queued record always holds between one and four results
  `ASSERT_RST(a_rec_cnt, clk_i, rst_ni, !out_valid_o || (head.cnt != '0 && head.cnt <= 3'(mhpt_pkg::MaxRes)), "bad record count")
  // More results of the same byte follow a result without run_last
  `ASSERT_RST(a_run_cont, clk_i, rst_ni, (out_valid_o && !out_stall_i && !out_data_o.run_last) |=> out_valid_o, "run broken")

endmodule

/* hw/rtl/mhpt_front.sv */
// Front end: tracks the parse phase and turns each byte into a record of results.
module mhpt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mhpt_pkg::in_item_t in_data_i,
  input  logic               accept_i,
  output mhpt_pkg::q_wr_t    q_wr_o
);

  mhpt_pkg::phase_e ph_q, ph_d;
  logic             esc_q, esc_d;
  mhpt_pkg::rec_t   rec;
  logic [7:0]       c;
  logic [7:0]       c_low;
  logic             blank;
  mhpt_pkg::kind_e  q_kind;
  mhpt_pkg::kind_e  q_end;

  assign c      = in_data_i.in_byte;
  assign blank  = (c == mhpt_pkg::ChSpace) || (c == mhpt_pkg::ChTab);
  assign c_low  = ((c >= mhpt_pkg::ChUpA) && (c <= mhpt_pkg::ChUpZ)) ? c + mhpt_pkg::CaseOfs : c;
  assign q_kind = (ph_q == mhpt_pkg::PhMainQuoted) ? mhpt_pkg::KMain : mhpt_pkg::KVal;
  assign q_end  = (ph_q == mhpt_pkg::PhMainQuoted) ? mhpt_pkg::KMainEnd : mhpt_pkg::KPairEnd;

  // Classify the byte against the current phase
  always_comb begin
    mhpt_pkg::phase_e ph_t;
    rec   = '0;
    ph_t  = ph_q;
    esc_d = esc_q;
    unique case (ph_q)
      mhpt_pkg::PhMainBare, mhpt_pkg::PhValBare: begin
        if (blank || c == mhpt_pkg::ChSemi) begin
          rec  = mhpt_pkg::rec_add(rec, (ph_q == mhpt_pkg::PhMainBare) ?
                                   mhpt_pkg::KMainEnd : mhpt_pkg::KPairEnd, 8'h00);
          ph_t = mhpt_pkg::PhKeySep;
        end else begin
          rec = mhpt_pkg::rec_add(rec, (ph_q == mhpt_pkg::PhMainBare) ?
                                  mhpt_pkg::KMain : mhpt_pkg::KVal, c);
        end
      end
      mhpt_pkg::PhMainQuoted, mhpt_pkg::PhValQuoted: begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (c != mhpt_pkg::ChStar && c != mhpt_pkg::ChBslash) begin
            rec = mhpt_pkg::rec_add(rec, q_kind, mhpt_pkg::ChBslash);
          end
          rec = mhpt_pkg::rec_add(rec, q_kind, c);
        end else if (c == mhpt_pkg::ChQuote) begin
          rec  = mhpt_pkg::rec_add(rec, q_end, 8'h00);
          ph_t = mhpt_pkg::PhKeySep;
        end else if (c == mhpt_pkg::ChBslash) begin
          esc_d = 1'b1;
        end else begin
          rec = mhpt_pkg::rec_add(rec, q_kind, c);
        end
      end
      mhpt_pkg::PhKeySep, mhpt_pkg::PhKeyBlank: begin
        if (ph_q == mhpt_pkg::PhKeyBlank && c == mhpt_pkg::ChEq) begin
          ph_t = mhpt_pkg::PhValSkip;
        end else if (ph_q == mhpt_pkg::PhKeyBlank && blank) begin
          ph_t = mhpt_pkg::PhKeyBlank;
        end else begin
          // close the pair of a blank-ended key, then start a key unless blank, ; or =
          if (ph_q == mhpt_pkg::PhKeyBlank) begin
            rec = mhpt_pkg::rec_add(rec, mhpt_pkg::KPairEnd, 8'h00);
          end
          if (blank || c == mhpt_pkg::ChSemi) begin
            ph_t = mhpt_pkg::PhKeySep;
          end else if (c == mhpt_pkg::ChEq) begin
            ph_t = mhpt_pkg::PhValSkip;
          end else begin
            rec  = mhpt_pkg::rec_add(rec, mhpt_pkg::KKey, c_low);
            ph_t = mhpt_pkg::PhKey;
          end
        end
      end
      mhpt_pkg::PhKey: begin
        if (c == mhpt_pkg::ChEq) begin
          ph_t = mhpt_pkg::PhValSkip;
        end else if (blank) begin
          ph_t = mhpt_pkg::PhKeyBlank;
        end else begin
          rec = mhpt_pkg::rec_add(rec, mhpt_pkg::KKey, c_low);
        end
      end
      mhpt_pkg::PhValSkip: begin
        if (blank) begin
          ph_t = mhpt_pkg::PhValSkip;
        end else if (c == mhpt_pkg::ChQuote) begin
          ph_t  = mhpt_pkg::PhValQuoted;
          esc_d = 1'b0;
        end else if (c == mhpt_pkg::ChSemi) begin
          rec  = mhpt_pkg::rec_add(rec, mhpt_pkg::KPairEnd, 8'h00);
          ph_t = mhpt_pkg::PhKeySep;
        end else begin
          rec  = mhpt_pkg::rec_add(rec, mhpt_pkg::KVal, c);
          ph_t = mhpt_pkg::PhValBare;
        end
      end
      default: begin
        if (blank) begin
          ph_t = mhpt_pkg::PhMainSkip;
        end else if (c == mhpt_pkg::ChQuote) begin
          ph_t  = mhpt_pkg::PhMainQuoted;
          esc_d = 1'b0;
        end else if (c == mhpt_pkg::ChSemi) begin
          rec  = mhpt_pkg::rec_add(rec, mhpt_pkg::KMainEnd, 8'h00);
          ph_t = mhpt_pkg::PhKeySep;
        end else begin
          rec  = mhpt_pkg::rec_add(rec, mhpt_pkg::KMain, c);
          ph_t = mhpt_pkg::PhMainBare;
        end
      end
    endcase

    // Close open items and mark the end of the line
    if (in_data_i.line_end) begin
      unique case (ph_t)
        mhpt_pkg::PhMainBare, mhpt_pkg::PhMainQuoted: begin
          rec = mhpt_pkg::rec_add(rec, mhpt_pkg::KMainEnd, 8'h00);
        end
        mhpt_pkg::PhKey, mhpt_pkg::PhKeyBlank, mhpt_pkg::PhValSkip,
        mhpt_pkg::PhValBare, mhpt_pkg::PhValQuoted: begin
          rec = mhpt_pkg::rec_add(rec, mhpt_pkg::KPairEnd, 8'h00);
        end
        default: begin
          rec = rec;
        end
      endcase
      rec   = mhpt_pkg::rec_add(rec, mhpt_pkg::KLineEnd, 8'h00);
      ph_t  = mhpt_pkg::PhMainSkip;
      esc_d = 1'b0;
    end
    ph_d = ph_t;
  end

  // Push only records that carry results
  assign q_wr_o.valid = accept_i && (rec.cnt != '0);
  assign q_wr_o.rec   = rec;

  // Advance the phase on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= mhpt_pkg::PhMainSkip;
      esc_q <= 1'b0;
    end else if (accept_i) begin
      ph_q  <= ph_d;
      esc_q <= esc_d;
    end
  end

endmodule

/* hw/rtl/mhpt_queue.sv */
// Short record queue between the front end and the back end.
module mhpt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mhpt_pkg::q_wr_t wr_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output mhpt_pkg::rec_t  head_o
);

  localparam int PtrW = (mhpt_pkg::QDepth > 1) ? $clog2(mhpt_pkg::QDepth) : 1;
  localparam int CntW = $clog2(mhpt_pkg::QDepth + 1);

  mhpt_pkg::rec_t      mem_q [mhpt_pkg::QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign full_o  = (cnt_q == CntW'(mhpt_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign push    = wr_i.valid && !full_o;
  assign pop     = pop_i && !empty_o;

  // Step pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mhpt_pkg::QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mhpt_pkg::QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.rec;
    end
  end

endmodule

/* hw/rtl/mhpt_back.sv */
// Back end: walks the head record and hands out one tagged byte per transaction.
module mhpt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  mhpt_pkg::rec_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhpt_pkg::out_item_t out_data_o
);

  logic [mhpt_pkg::ResIdxW-1:0] idx_q, idx_d;
  logic                         last;
  logic                         take;

  assign last        = (mhpt_pkg::ResCntW'(idx_q) + mhpt_pkg::ResCntW'(1)) == head_i.cnt;
  assign out_valid_o = !empty_i;
  assign take        = out_valid_o && !out_stall_i;
  assign pop_o       = take && last;

  // Present the current result of the head record
  assign out_data_o.kind     = head_i.res[idx_q].kind;
  assign out_data_o.out_byte = head_i.res[idx_q].data;
  assign out_data_o.run_last = last;

  // Advance within the record, restart on the next one
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last ? '0 : idx_q + mhpt_pkg::ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
